[rtl/core/long_press_key_detector_core_defines.svh]
// ----------------------------------------------------------------------------
// Long-press key detector assertion macros
// Shared concurrent check forms for the core.
// ----------------------------------------------------------------------------
`ifndef LONG_PRESS_KEY_DETECTOR_CORE_DEFINES_SVH
`define LONG_PRESS_KEY_DETECTOR_CORE_DEFINES_SVH

// same-cycle implication
`define LPK_ASSERT_NOW(lbl, ck, rn, a, b, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define LPK_ASSERT_NEXT(lbl, ck, rn, a, b, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) else $error(msg);

`endif

[rtl/core/lpk_pkg.sv]
// ----------------------------------------------------------------------------
// Long-press key detector package
// Request, result and table entry types plus action and kind codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpk_pkg;

    localparam logic [2:0] ACT_REGISTER   = 3'd0;
    localparam logic [2:0] ACT_UNREGISTER = 3'd1;
    localparam logic [2:0] ACT_KEY_DOWN   = 3'd2;
    localparam logic [2:0] ACT_KEY_UP     = 3'd3;
    localparam logic [2:0] ACT_TICK       = 3'd4;

    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_EVENT   = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    localparam logic [7:0]  REL_BIT  = 8'h80;
    localparam logic [31:0] TMO_NONE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  action;
        logic [6:0]  scan_code;
        logic [15:0] short_code;
        logic [7:0]  long_code;
        logic [15:0] hold_ms;
        logic        eat_short_down;
        logic        eat_short_up;
        logic        eat_long_up;
        logic        repeat_req;
        logic [15:0] elapsed_ms;
        logic [15:0] tick_ms;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        ok;
        logic        pass_short_down;
        logic        pass_short_up;
        logic [7:0]  event_scan;
        logic [7:0]  event_code;
        logic        event_press;
        logic [31:0] timeout_ms;
        logic        last;
    } rsp_t;

    // opts: bit0 eat short down, bit1 eat short up or down, bit2 eat long up, bit3 repeat
    typedef struct packed {
        logic [6:0]  scan;
        logic [15:0] short_code;
        logic [7:0]  long_code;
        logic [15:0] hold;
        logic [31:0] remaining;
        logic [3:0]  opts;
        logic        held;
        logic        fired;
    } entry_t;

endpackage

[rtl/core/long_press_key_detector_core.sv]
// ----------------------------------------------------------------------------
// Long-press key detector core
// Table of long-press bindings in a synchronous memory, scanned one entry
// per read/modify/write step for key down, key up, tick and unregister.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   request (req_t)                start & !busy
//  result    result (rsp_t)                 result_valid, one cycle each
//
//  Register writes a free entry, then gives its result. Unregister, key
//  down, key up, tick: each scanned entry takes a memory read step, then a
//  modify/write step; unregister stops at its first match. Key down closes
//  with two results, the others with one. Valid bits live in flops and clear
//  at reset, so no clearing pass is needed. Results cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "long_press_key_detector_core_defines.svh"

module long_press_key_detector_core
    import lpk_pkg::*;
#(
    parameter int ENTRIES = 8
)(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t request,
    output logic busy,
    output logic result_valid,
    output rsp_t result
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_REG, S_RD, S_PR, S_FIN, S_FIN2
    } state_t;

    state_t             state_reg;
    req_t               req_reg;
    logic [IW-1:0]      idx_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic               ok_reg;
    logic               psd_reg;
    logic               psu_reg;
    logic [31:0]        tmo_reg;
    logic               result_valid_reg;
    rsp_t               result_reg;

    entry_t entry_mem [ENTRIES];
    entry_t rdata_reg;

    logic          we;
    logic [IW-1:0] waddr;
    entry_t        wdata;

    logic          free_found;
    logic [IW-1:0] free_idx;
    logic [3:0]    reg_opts;
    logic          reg_ok;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    assign reg_opts = {req_reg.repeat_req, req_reg.eat_long_up,
                       req_reg.eat_short_up | req_reg.eat_short_down,
                       req_reg.eat_short_down};
    assign reg_ok = (req_reg.hold_ms != 16'd0) && !(reg_opts[1] && reg_opts[2])
                    && free_found;

    logic        cur_valid;
    logic        key_match;
    logic        full_match;
    logic        last_idx;
    logic [31:0] kd_rem;
    logic [31:0] tick32;
    logic        tick_elig;
    logic        tick_fire;
    logic [31:0] tick_rem;

    assign cur_valid  = valid_reg[idx_reg];
    assign key_match  = (rdata_reg.scan == req_reg.scan_code) ||
                        (rdata_reg.short_code == req_reg.short_code);
    assign full_match = (rdata_reg.scan == req_reg.scan_code) &&
                        (rdata_reg.short_code == req_reg.short_code) &&
                        (rdata_reg.long_code == req_reg.long_code) &&
                        (rdata_reg.hold == req_reg.hold_ms);
    assign last_idx   = (idx_reg == IW'(ENTRIES - 1));
    assign kd_rem     = {16'd0, rdata_reg.hold} + {16'd0, req_reg.elapsed_ms};
    assign tick32     = {16'd0, req_reg.tick_ms};
    assign tick_elig  = cur_valid && rdata_reg.held &&
                        (!rdata_reg.fired || rdata_reg.opts[3]);
    assign tick_fire  = rdata_reg.remaining <= tick32;
    assign tick_rem   = tick_fire ? {16'd0, rdata_reg.hold}
                                  : rdata_reg.remaining - tick32;

    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg;
        wdata = rdata_reg;
        if (state_reg == S_REG)
        begin
            we               = reg_ok;
            waddr            = free_idx;
            wdata.scan       = req_reg.scan_code;
            wdata.short_code = req_reg.short_code;
            wdata.long_code  = req_reg.long_code;
            wdata.hold       = req_reg.hold_ms;
            wdata.remaining  = '0;
            wdata.opts       = reg_opts;
            wdata.held       = 1'b0;
            wdata.fired      = 1'b0;
        end
        else if (state_reg == S_PR)
        begin
            case (req_reg.action)
                ACT_KEY_DOWN:
                begin
                    we              = cur_valid && !rdata_reg.held && key_match;
                    wdata.remaining = kd_rem;
                    wdata.held      = 1'b1;
                    wdata.fired     = 1'b0;
                end
                ACT_KEY_UP:
                begin
                    we              = cur_valid && key_match;
                    wdata.remaining = '0;
                    wdata.held      = 1'b0;
                    wdata.fired     = 1'b0;
                end
                ACT_TICK:
                begin
                    we              = tick_elig;
                    wdata.remaining = tick_rem;
                    wdata.fired     = tick_fire | rdata_reg.fired;
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_mem[waddr] <= wdata;
        end
        rdata_reg <= entry_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            valid_reg        <= '0;
            idx_reg          <= '0;
            result_valid_reg <= 1'b0;
            ok_reg           <= 1'b0;
            psd_reg          <= 1'b0;
            psu_reg          <= 1'b0;
            tmo_reg          <= TMO_NONE;
            req_reg          <= '0;
            result_reg       <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg <= request;
                        idx_reg <= '0;
                        ok_reg  <= 1'b0;
                        tmo_reg <= TMO_NONE;
                        psd_reg <= (request.action == ACT_KEY_DOWN);
                        psu_reg <= 1'b1;
                        if (request.action == ACT_REGISTER)
                        begin
                            state_reg <= S_REG;
                        end
                        else if (request.action == ACT_UNREGISTER &&
                                 request.hold_ms == 16'd0)
                        begin
                            state_reg <= S_FIN;
                        end
                        else if (request.action inside {ACT_UNREGISTER, ACT_KEY_DOWN,
                                                        ACT_KEY_UP, ACT_TICK})
                        begin
                            state_reg <= S_RD;
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_REG:
                begin
                    ok_reg <= reg_ok;
                    if (reg_ok)
                    begin
                        valid_reg[free_idx] <= 1'b1;
                    end
                    state_reg <= S_FIN;
                end
                S_RD:
                begin
                    state_reg <= S_PR;
                end
                S_PR:
                begin
                    state_reg <= last_idx ? S_FIN : S_RD;
                    idx_reg   <= idx_reg + IW'(1);
                    case (req_reg.action)
                        ACT_UNREGISTER:
                        begin
                            if (cur_valid && full_match)
                            begin
                                valid_reg[idx_reg] <= 1'b0;
                                ok_reg             <= 1'b1;
                                state_reg          <= S_FIN;
                            end
                        end
                        ACT_KEY_DOWN:
                        begin
                            if (cur_valid && !rdata_reg.held && key_match)
                            begin
                                if (rdata_reg.opts[0])
                                begin
                                    psd_reg <= 1'b0;
                                end
                                if (kd_rem < tmo_reg)
                                begin
                                    tmo_reg <= kd_rem;
                                end
                            end
                        end
                        ACT_KEY_UP:
                        begin
                            if (cur_valid && key_match)
                            begin
                                if (rdata_reg.fired)
                                begin
                                    if (rdata_reg.opts[0] || rdata_reg.opts[1])
                                    begin
                                        psu_reg <= 1'b0;
                                    end
                                    if (!rdata_reg.opts[2])
                                    begin
                                        result_valid_reg      <= 1'b1;
                                        result_reg.kind       <= KIND_EVENT;
                                        result_reg.event_scan <=
                                            {1'b0, req_reg.scan_code} | REL_BIT;
                                        result_reg.event_code <= rdata_reg.long_code;
                                    end
                                end
                                else if (rdata_reg.held && rdata_reg.opts[0])
                                begin
                                    psd_reg <= 1'b1;
                                end
                            end
                        end
                        ACT_TICK:
                        begin
                            if (tick_elig)
                            begin
                                if (tick_rem < tmo_reg)
                                begin
                                    tmo_reg <= tick_rem;
                                end
                                if (tick_fire)
                                begin
                                    result_valid_reg       <= 1'b1;
                                    result_reg.kind        <= KIND_EVENT;
                                    result_reg.event_scan  <= {1'b0, rdata_reg.scan};
                                    result_reg.event_code  <= rdata_reg.long_code;
                                    result_reg.event_press <= 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            state_reg <= S_FIN;
                        end
                    endcase
                end
                S_FIN:
                begin
                    result_valid_reg <= 1'b1;
                    result_reg.last  <= 1'b1;
                    state_reg        <= S_IDLE;
                    case (req_reg.action)
                        ACT_REGISTER, ACT_UNREGISTER:
                        begin
                            result_reg.ok <= ok_reg;
                        end
                        ACT_KEY_DOWN:
                        begin
                            result_reg.pass_short_down <= psd_reg;
                            result_reg.last            <= 1'b0;
                            state_reg                  <= S_FIN2;
                        end
                        ACT_KEY_UP:
                        begin
                            result_reg.pass_short_down <= psd_reg;
                            result_reg.pass_short_up   <= psu_reg;
                        end
                        ACT_TICK:
                        begin
                            result_reg.kind       <= KIND_TIMEOUT;
                            result_reg.timeout_ms <= tmo_reg;
                        end
                        default:
                        begin
                            result_reg.kind <= KIND_STATUS;
                        end
                    endcase
                end
                S_FIN2:
                begin
                    result_valid_reg      <= 1'b1;
                    result_reg.kind       <= KIND_TIMEOUT;
                    result_reg.timeout_ms <= tmo_reg;
                    result_reg.last       <= 1'b1;
                    state_reg             <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `LPK_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy,
        "request accepted but core not busy")
    `LPK_ASSERT_NOW(a_last_on_idle, clk, rst_n, !busy && $past(busy),
        result_valid && result.last, "core went idle without final result")
    `LPK_ASSERT_NOW(a_mid_busy, clk, rst_n, result_valid && !result.last, busy,
        "non-final result while idle")

endmodule
